/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros
// Assertion macros used by the checker file pdd_checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define PDD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pdd assertion failed");

// next-cycle implication, disabled while reset is low
`define PDD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pdd assertion failed");

`endif

/* src/pdd_pkg.sv */
// ----------------------------------------------------------------------------
// pdd_pkg
// Types, constants and helper functions of the differential drive controller.
// ----------------------------------------------------------------------------
package pdd_pkg;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_PROP  = 3'd0,
        CFG_DERIV = 3'd1,
        CFG_INTEG = 3'd2,
        CFG_LIMIT = 3'd3,
        CFG_SPAN  = 3'd4
    } t_cfg_idx;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int GAIN_W     = 16;
    localparam int LIMIT_W    = 15;
    localparam int SPAN_W     = 8;
    localparam int BASE_W     = 10;
    localparam int INTEG_W    = 16;
    localparam int DRIVE_W    = 24;   // clamped Q1.22 drive, +/-(1<<22)
    localparam int MPROD_W    = DRIVE_W + SPAN_W + 1;
    localparam int NUM_W      = 34;   // base<<22 plus steering term
    localparam int MOTOR_FRAC = 22;
    localparam int Q_W        = NUM_W - MOTOR_FRAC;
    localparam int DQ_W       = 16;
    localparam int FIELD_W    = 10;
    localparam int CMD_W      = 26;

    localparam logic [GAIN_W-1:0]  PROP_RST  = 16'd1280;
    localparam logic [GAIN_W-1:0]  DERIV_RST = 16'd3072;
    localparam logic [GAIN_W-1:0]  INTEG_RST = 16'd154;
    localparam logic [LIMIT_W-1:0] LIMIT_RST = 15'd6554;
    localparam logic [SPAN_W-1:0]  SPAN_RST  = 8'd70;

    localparam logic signed [DRIVE_W-1:0] ONE_Q22     = 24'sh400000;
    localparam logic signed [DRIVE_W-1:0] NEG_ONE_Q22 = 24'shC00000;

    localparam logic signed [Q_W-1:0] MOTOR_MAX     = 12'sd255;
    localparam logic signed [Q_W-1:0] NEG_MOTOR_MAX = -12'sd255;

    localparam logic [1:0] DIR_FWD = 2'd2;
    localparam logic [1:0] DIR_REV = 2'd0;

    typedef enum logic [1:0] {
        MS_PROP  = 2'd0,
        MS_DERIV = 2'd1,
        MS_INTEG = 2'd2
    } t_mul_sel;

    typedef enum logic [1:0] {
        ACC_HOLD = 2'd0,
        ACC_LOAD = 2'd1,
        ACC_ADD  = 2'd2
    } t_acc_op;

    typedef struct packed {
        logic     load;
        logic     integ;
        logic     mul_en;
        t_mul_sel mul_sel;
        t_acc_op  acc_op;
        logic     clamp;
        logic     motor;
        logic     pack;
    } t_dp_cmd;

    // truncate toward zero, saturate to +/-255, split into direction and magnitude
    function automatic logic [FIELD_W-1:0] motor_field(input logic signed [NUM_W-1:0] num);
        logic signed [Q_W-1:0] q;
        logic signed [Q_W-1:0] m;
        logic signed [Q_W-1:0] neg_m;
        logic [1:0]            dir;
        logic [7:0]            mag;
        q = num[NUM_W-1:MOTOR_FRAC];
        if (num[NUM_W-1] && (num[MOTOR_FRAC-1:0] != '0)) begin
            q = q + 12'sd1;
        end
        if (q > MOTOR_MAX) begin
            m = MOTOR_MAX;
        end else if (q < NEG_MOTOR_MAX) begin
            m = NEG_MOTOR_MAX;
        end else begin
            m = q;
        end
        neg_m = -m;
        if (m < 0) begin
            dir = DIR_REV;
            mag = neg_m[7:0];
        end else begin
            dir = DIR_FWD;
            mag = m[7:0];
        end
        return {dir, mag};
    endfunction

endpackage

/* src/pdd_ctrl.sv */
// ----------------------------------------------------------------------------
// pdd_ctrl
// Sequencer of the controller: steps the datapath through one sample.
// ----------------------------------------------------------------------------
module pdd_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    output logic              o_valid,
    input  logic              i_stall,
    output pdd_pkg::t_dp_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_INTEG,
        S_MULP,
        S_MULD,
        S_MULI,
        S_SUM,
        S_CLAMP,
        S_MOTOR,
        S_PACK
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;
    logic   in_xfer;

    assign out_free = !r_out_valid || !i_stall;
    assign in_xfer  = (r_state == S_IDLE) && i_valid;
    assign o_stall  = (r_state != S_IDLE);
    assign o_valid  = r_out_valid;

    always_comb begin
        n_state        = r_state;
        o_cmd          = '0;
        o_cmd.mul_sel  = pdd_pkg::MS_PROP;
        o_cmd.acc_op   = pdd_pkg::ACC_HOLD;
        case (r_state)
            S_IDLE: begin
                o_cmd.load = in_xfer;
                if (in_xfer) begin
                    n_state = S_INTEG;
                end
            end
            S_INTEG: begin
                o_cmd.integ = 1'b1;
                n_state     = S_MULP;
            end
            S_MULP: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = pdd_pkg::MS_PROP;
                n_state       = S_MULD;
            end
            S_MULD: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = pdd_pkg::MS_DERIV;
                o_cmd.acc_op  = pdd_pkg::ACC_LOAD;
                n_state       = S_MULI;
            end
            S_MULI: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = pdd_pkg::MS_INTEG;
                o_cmd.acc_op  = pdd_pkg::ACC_ADD;
                n_state       = S_SUM;
            end
            S_SUM: begin
                o_cmd.acc_op = pdd_pkg::ACC_ADD;
                n_state      = S_CLAMP;
            end
            S_CLAMP: begin
                o_cmd.clamp = 1'b1;
                n_state     = S_MOTOR;
            end
            S_MOTOR: begin
                o_cmd.motor = 1'b1;
                n_state     = S_PACK;
            end
            S_PACK: begin
                // wait until the output register is free
                o_cmd.pack = out_free;
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.pack) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

/* src/pdd_dp.sv */
// ----------------------------------------------------------------------------
// pdd_dp
// Datapath: configuration registers, integrator, shared gain multiplier,
// accumulator, clamp, motor mixing and output register.
// ----------------------------------------------------------------------------
module pdd_dp #(
    parameter int ERROR_WIDTH = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  pdd_pkg::t_dp_cmd                    i_cmd,
    input  logic signed [ERROR_WIDTH-1:0]       i_error_in,
    input  logic signed [pdd_pkg::BASE_W-1:0]   i_base_speed,
    input  logic                                i_cfg_we,
    input  logic [pdd_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [pdd_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    output logic [pdd_pkg::CMD_W-1:0]           o_command_word,
    output logic signed [pdd_pkg::DQ_W-1:0]     o_drive_value
);

    localparam int SW  = ((ERROR_WIDTH > pdd_pkg::INTEG_W) ? ERROR_WIDTH
                                                           : pdd_pkg::INTEG_W) + 1;
    localparam int DW  = ERROR_WIDTH + 1;
    localparam int AW  = (DW > pdd_pkg::INTEG_W) ? DW : pdd_pkg::INTEG_W;
    localparam int BW  = pdd_pkg::GAIN_W + 1;
    localparam int PW  = AW + BW;
    localparam int ACW = PW + 2;

    localparam logic signed [ACW-1:0] ONE_ACC     = ACW'(pdd_pkg::ONE_Q22);
    localparam logic signed [ACW-1:0] NEG_ONE_ACC = ACW'(pdd_pkg::NEG_ONE_Q22);

    // configuration
    logic [pdd_pkg::GAIN_W-1:0]  r_prop_gain;
    logic [pdd_pkg::GAIN_W-1:0]  r_deriv_gain;
    logic [pdd_pkg::GAIN_W-1:0]  r_integ_gain;
    logic [pdd_pkg::LIMIT_W-1:0] r_integ_limit;
    logic [pdd_pkg::SPAN_W-1:0]  r_steer_span;

    // loop state
    logic signed [pdd_pkg::INTEG_W-1:0] r_integral;
    logic signed [ERROR_WIDTH-1:0]      r_last_error;

    // per-sample working registers
    logic signed [ERROR_WIDTH-1:0]       r_err;
    logic signed [pdd_pkg::BASE_W-1:0]   r_base;
    logic signed [DW-1:0]                r_diff;
    logic signed [PW-1:0]                r_prod;
    logic signed [ACW-1:0]               r_acc;
    logic signed [pdd_pkg::DRIVE_W-1:0]  r_drive;
    logic signed [pdd_pkg::MPROD_W-1:0]  r_mprod;
    logic signed [pdd_pkg::DQ_W-1:0]     r_dq;
    logic [pdd_pkg::CMD_W-1:0]           r_cmd_word;
    logic signed [pdd_pkg::DQ_W-1:0]     r_drive_out;

    logic signed [SW-1:0]                integ_sum;
    logic signed [SW-1:0]                lim_pos;
    logic signed [SW-1:0]                lim_neg;
    logic signed [pdd_pkg::INTEG_W-1:0]  integ_next;
    logic signed [DW-1:0]                diff_next;
    logic signed [AW-1:0]                mul_a;
    logic [pdd_pkg::GAIN_W-1:0]          gain_sel;
    logic signed [BW-1:0]                mul_b;
    logic signed [pdd_pkg::DRIVE_W-1:0]  drive_next;
    logic signed [pdd_pkg::DRIVE_W-1:0]  drive_rnd;
    logic signed [pdd_pkg::DRIVE_W-1:0]  drive_shr;
    logic signed [pdd_pkg::NUM_W-1:0]    base_sh;
    logic signed [pdd_pkg::NUM_W-1:0]    mprod_ext;
    logic signed [pdd_pkg::NUM_W-1:0]    num_left;
    logic signed [pdd_pkg::NUM_W-1:0]    num_right;
    logic [pdd_pkg::FIELD_W-1:0]         field_left;
    logic [pdd_pkg::FIELD_W-1:0]         field_right;

    // integrator update with clamp to +/- limit
    assign integ_sum = SW'(r_integral) + SW'(r_err);
    assign lim_pos   = $signed({{(SW-pdd_pkg::LIMIT_W){1'b0}}, r_integ_limit});
    assign lim_neg   = -lim_pos;

    always_comb begin
        if (integ_sum > lim_pos) begin
            integ_next = lim_pos[pdd_pkg::INTEG_W-1:0];
        end else if (integ_sum < lim_neg) begin
            integ_next = lim_neg[pdd_pkg::INTEG_W-1:0];
        end else begin
            integ_next = integ_sum[pdd_pkg::INTEG_W-1:0];
        end
    end

    assign diff_next = DW'(r_err) - DW'(r_last_error);

    // shared gain multiplier operand select
    always_comb begin
        case (i_cmd.mul_sel)
            pdd_pkg::MS_PROP: begin
                mul_a    = AW'(r_err);
                gain_sel = r_prop_gain;
            end
            pdd_pkg::MS_DERIV: begin
                mul_a    = AW'(r_diff);
                gain_sel = r_deriv_gain;
            end
            pdd_pkg::MS_INTEG: begin
                mul_a    = AW'(r_integral);
                gain_sel = r_integ_gain;
            end
            default: begin
                mul_a    = '0;
                gain_sel = '0;
            end
        endcase
    end

    assign mul_b = $signed({1'b0, gain_sel});

    // clamp the accumulated sum to +/-1.0 in Q1.22
    always_comb begin
        if (r_acc > ONE_ACC) begin
            drive_next = pdd_pkg::ONE_Q22;
        end else if (r_acc < NEG_ONE_ACC) begin
            drive_next = pdd_pkg::NEG_ONE_Q22;
        end else begin
            drive_next = r_acc[pdd_pkg::DRIVE_W-1:0];
        end
    end

    // Q1.22 to Q1.14 toward zero
    assign drive_rnd = r_drive + (r_drive[pdd_pkg::DRIVE_W-1] ? 24'sd255 : 24'sd0);
    assign drive_shr = drive_rnd >>> 8;

    // motor mixing
    assign base_sh     = $signed({{(pdd_pkg::NUM_W - pdd_pkg::BASE_W - pdd_pkg::MOTOR_FRAC)
                                   {r_base[pdd_pkg::BASE_W-1]}},
                                  r_base, {pdd_pkg::MOTOR_FRAC{1'b0}}});
    assign mprod_ext   = pdd_pkg::NUM_W'(r_mprod);
    assign num_left    = base_sh + mprod_ext;
    assign num_right   = base_sh - mprod_ext;
    assign field_left  = pdd_pkg::motor_field(num_left);
    assign field_right = pdd_pkg::motor_field(num_right);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prop_gain   <= pdd_pkg::PROP_RST;
            r_deriv_gain  <= pdd_pkg::DERIV_RST;
            r_integ_gain  <= pdd_pkg::INTEG_RST;
            r_integ_limit <= pdd_pkg::LIMIT_RST;
            r_steer_span  <= pdd_pkg::SPAN_RST;
            r_integral    <= '0;
            r_last_error  <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    pdd_pkg::CFG_PROP:  r_prop_gain   <= i_cfg_data;
                    pdd_pkg::CFG_DERIV: r_deriv_gain  <= i_cfg_data;
                    pdd_pkg::CFG_INTEG: r_integ_gain  <= i_cfg_data;
                    pdd_pkg::CFG_LIMIT: r_integ_limit <= i_cfg_data[pdd_pkg::LIMIT_W-1:0];
                    pdd_pkg::CFG_SPAN:  r_steer_span  <= i_cfg_data[pdd_pkg::SPAN_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (i_cmd.integ) begin
                r_integral   <= integ_next;
                r_last_error <= r_err;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_err  <= i_error_in;
            r_base <= i_base_speed;
        end
        if (i_cmd.integ) begin
            r_diff <= diff_next;
        end
        if (i_cmd.mul_en) begin
            r_prod <= mul_a * mul_b;
        end
        case (i_cmd.acc_op)
            pdd_pkg::ACC_LOAD: r_acc <= ACW'(r_prod);
            pdd_pkg::ACC_ADD:  r_acc <= r_acc + ACW'(r_prod);
            default: begin
            end
        endcase
        if (i_cmd.clamp) begin
            r_drive <= drive_next;
        end
        if (i_cmd.motor) begin
            r_mprod <= r_drive * $signed({1'b0, r_steer_span});
            r_dq    <= drive_shr[pdd_pkg::DQ_W-1:0];
        end
        if (i_cmd.pack) begin
            r_cmd_word  <= {field_left, 6'b0, field_right};
            r_drive_out <= r_dq;
        end
    end

    assign o_command_word = r_cmd_word;
    assign o_drive_value  = r_drive_out;

endmodule

/* src/pid_differential_drive_top.sv */
// ----------------------------------------------------------------------------
// pid_differential_drive_top
// PID steering controller with integrator clamp for a differential drive.
// ----------------------------------------------------------------------------
// Each accepted sample (Q1.14 error, signed base speed) yields one result:
// a packed left/right motor command word and the clamped Q1.14 drive value.
// After its input transfer a sample passes through the integrator step, the
// three gain products running in turn through one shared multiplier, the last
// accumulate, and the clamp, steering product and packing steps, before the
// result stands in the output register. A new sample is taken only once the
// previous one is packed and the block is back in idle. A stalled result at
// the output holds the packing step, and with it the input, until the result
// is taken. The output register holds a finished result while the next sample
// is being worked on. The user must write gains, limit and span through the
// configuration port only while the block is idle; the block itself does not
// enforce this.
module pid_differential_drive_top #(
    parameter int ERROR_WIDTH = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic signed [ERROR_WIDTH-1:0]       i_error_in,
    input  logic signed [pdd_pkg::BASE_W-1:0]   i_base_speed,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [pdd_pkg::CMD_W-1:0]           o_command_word,
    output logic signed [pdd_pkg::DQ_W-1:0]     o_drive_value,
    input  logic                                i_cfg_we,
    input  logic [pdd_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [pdd_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    pdd_pkg::t_dp_cmd dp_cmd;

    pdd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_cmd   (dp_cmd)
    );

    pdd_dp #(
        .ERROR_WIDTH (ERROR_WIDTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (dp_cmd),
        .i_error_in     (i_error_in),
        .i_base_speed   (i_base_speed),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .o_command_word (o_command_word),
        .o_drive_value  (o_drive_value)
    );

endmodule

/* src/pdd_checker.sv */
// ----------------------------------------------------------------------------
// pdd_checker
// Port-level checks of the differential drive controller, bound to the top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pdd_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_valid,
    input logic                               o_stall,
    input logic                               o_valid,
    input logic                               i_stall,
    input logic [pdd_pkg::CMD_W-1:0]          o_command_word,
    input logic signed [pdd_pkg::DQ_W-1:0]    o_drive_value
);

    localparam logic signed [pdd_pkg::DQ_W-1:0] DRV_MAX = 16'sd16384;
    localparam logic signed [pdd_pkg::DQ_W-1:0] DRV_MIN = -16'sd16384;

    logic                                      in_xfer;
    logic [pdd_pkg::CMD_W+pdd_pkg::DQ_W-1:0]   out_word;
    logic                                      drive_ok;
    logic                                      cmd_ok;

    assign in_xfer  = i_valid && !o_stall;
    assign out_word = {o_command_word, o_drive_value};
    assign drive_ok = (o_drive_value <= DRV_MAX) && (o_drive_value >= DRV_MIN);
    assign cmd_ok   = (o_command_word[15:10] == 6'd0) && !o_command_word[24]
                      && !o_command_word[8];

    // a stalled result holds
    `PDD_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(out_word))

    // drive stays within +/-1.0
    `PDD_ASSERT_IMP(a_drive_range, i_clk, i_rst_n, o_valid, drive_ok)

    // direction codes are forward or reverse and the gap bits stay clear
    `PDD_ASSERT_IMP(a_cmd_format, i_clk, i_rst_n, o_valid, cmd_ok)

    // a transfer in makes the block busy on the next cycle
    `PDD_ASSERT_NXT(a_busy_after_xfer, i_clk, i_rst_n, in_xfer, o_stall)

endmodule

bind pid_differential_drive_top pdd_checker u_pdd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_stall        (o_stall),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_command_word (o_command_word),
    .o_drive_value  (o_drive_value)
);
